FILE: rtl/core/dbi_pkg.sv
// Package for the dual button debouncer: widths, register map, edge phase
// encoding and the per-button lane result record. No dependencies.
package dbi_pkg;

    localparam int TIME_BITS = 32;
    localparam int CNT_BITS  = 8;
    localparam int HOLD_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam int APB_BITS  = 32;

    // Request layout on the input stream: pin_a_level, pin_b_level, now_time.
    localparam int IN_FIELD_BITS = 2 + TIME_BITS;
    localparam int IN_BITS       = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Result layout on the output stream, lowest bit first.
    localparam int A_PRESSED_BIT = 0;
    localparam int A_RISE_BIT    = 1;
    localparam int A_FALL_BIT    = 2;
    localparam int A_DUR_LSB     = 3;
    localparam int B_PRESSED_BIT = A_DUR_LSB + TIME_BITS;
    localparam int B_RISE_BIT    = B_PRESSED_BIT + 1;
    localparam int B_FALL_BIT    = B_PRESSED_BIT + 2;
    localparam int B_DUR_LSB     = B_PRESSED_BIT + 3;
    localparam int REQ_BIT       = B_DUR_LSB + TIME_BITS;
    localparam int OUT_FIELD_BITS = REQ_BIT + 1;
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [CNT_BITS-1:0]  INTEGRATOR_MAX_RESET  = CNT_BITS'(10);
    localparam logic [HOLD_BITS-1:0] RESET_HOLD_TIME_RESET = HOLD_BITS'(3000);

    typedef enum logic [0:0] {
        REG_INTEGRATOR_MAX = 1'b0,
        REG_RESET_HOLD     = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_UNPRESSED = 2'd0,
        PH_RISING    = 2'd1,
        PH_PRESSED   = 2'd2,
        PH_FALLING   = 2'd3
    } edge_phase_t;

    typedef struct packed {
        logic                 pressed;
        logic                 rise;
        logic                 fall;
        logic [TIME_BITS-1:0] duration;
    } lane_out_t;

endpackage

FILE: rtl/core/dbi_lane.sv
// One button lane: saturating integrator, debounced level, edge phase tracker
// and press start capture, with a registered per-button result. Uses dbi_pkg.
module dbi_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          pin_level,
    input  logic [dbi_pkg::TIME_BITS-1:0] now_time,
    input  logic [dbi_pkg::CNT_BITS-1:0]  integrator_max,
    output dbi_pkg::lane_out_t            lane_out
);
    import dbi_pkg::*;

    logic [CNT_BITS-1:0]  cnt_reg, cnt_next, cnt_step;
    logic                 level_reg, level_next;
    edge_phase_t          phase_reg, phase_next, phase_settled;
    logic [TIME_BITS-1:0] start_reg, start_next;
    lane_out_t            out_reg, out_next;

    always_comb begin
        if (!pin_level) begin
            cnt_step = (cnt_reg != '0) ? cnt_reg - CNT_BITS'(1) : cnt_reg;
        end else begin
            cnt_step = (cnt_reg < integrator_max) ? cnt_reg + CNT_BITS'(1) : cnt_reg;
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_RISING:  phase_settled = PH_PRESSED;
            PH_FALLING: phase_settled = PH_UNPRESSED;
            default:    phase_settled = phase_reg;
        endcase
    end

    always_comb begin
        phase_next = phase_settled;
        if (cnt_step == '0) begin
            if (level_reg) begin
                phase_next = PH_FALLING;
            end
        end else if (cnt_step >= integrator_max) begin
            if (phase_settled == PH_UNPRESSED) begin
                phase_next = PH_RISING;
            end
        end
    end

    always_comb begin
        cnt_next   = cnt_step;
        level_next = level_reg;
        start_next = start_reg;
        if (cnt_step == '0) begin
            level_next = 1'b0;
        end else if (cnt_step >= integrator_max) begin
            if (phase_settled == PH_UNPRESSED) begin
                start_next = now_time;
            end
            level_next = 1'b1;
            cnt_next   = integrator_max;
        end
    end

    always_comb begin
        out_next.pressed  = level_next;
        out_next.rise     = (phase_next == PH_RISING);
        out_next.fall     = (phase_next == PH_FALLING);
        out_next.duration = level_next ? now_time - start_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            level_reg <= 1'b0;
            phase_reg <= PH_UNPRESSED;
            start_reg <= '0;
            out_reg   <= '0;
        end else if (advance) begin
            cnt_reg   <= cnt_next;
            level_reg <= level_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
            out_reg   <= out_next;
        end
    end

    assign lane_out = out_reg;

    a_rise_while_high : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RISING |-> level_reg)
        else $error("rising phase with a low debounced level");

    a_fall_while_low : assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FALLING |-> !level_reg)
        else $error("falling phase with a high debounced level");

    a_duration_released : assert property (@(posedge aclk) disable iff (!aresetn)
        !out_reg.pressed |-> out_reg.duration == '0)
        else $error("nonzero duration for a released button");

    a_rise_pulse : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_reg == PH_RISING |=> phase_reg != PH_RISING)
        else $error("rising pulse lasted more than one tick");

endmodule

FILE: rtl/core/dbi_merge.sv
// Merge stage: combines both lane results, compares the hold durations with the
// reset hold time and holds the result on the output stream. Uses dbi_pkg.
module dbi_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dbi_pkg::lane_out_t            lane_a,
    input  dbi_pkg::lane_out_t            lane_b,
    input  logic [dbi_pkg::HOLD_BITS-1:0] reset_hold_time,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dbi_pkg::OUT_BITS-1:0]  m_tdata
);
    import dbi_pkg::*;

    logic                valid_reg, valid_next;
    logic [OUT_BITS-1:0] data_reg, data_next;
    logic                load;
    logic                reset_req;

    assign in_ready  = !valid_reg || m_tready;
    assign load      = in_valid && in_ready;
    assign reset_req = (lane_a.duration > reset_hold_time) &&
                       (lane_b.duration > reset_hold_time);

    assign data_next = OUT_BITS'({reset_req,
                                  lane_b.duration, lane_b.fall, lane_b.rise, lane_b.pressed,
                                  lane_a.duration, lane_a.fall, lane_a.rise, lane_a.pressed});

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    a_req_needs_both : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg[REQ_BIT] |-> data_reg[A_PRESSED_BIT] && data_reg[B_PRESSED_BIT])
        else $error("reset request without both buttons pressed");

    a_req_needs_time : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg[REQ_BIT] |->
            data_reg[A_DUR_LSB +: TIME_BITS] != '0 && data_reg[B_DUR_LSB +: TIME_BITS] != '0)
        else $error("reset request with a zero hold duration");

    a_load_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: rtl/core/dual_button_integrator_debounce_unit.sv
// Top level of the dual button debouncer: configuration registers, request
// intake and the two button lanes feeding the merge stage. Uses dbi_pkg,
// dbi_lane and dbi_merge.
//
// Each request carries both raw pin levels and the current tick count and
// yields exactly one result, registered in the lane stage and then in the merge
// stage. A new request is taken every cycle: the lane stage updates the
// per-button integrator and edge state, and the merge stage registers the hold
// time comparison, so the sustained rate is one request per cycle while the
// result side keeps up. Configuration is written through the APB port at byte
// address 0 (integrator maximum, 8 bits) and 4 (reset hold time, 32 bits).
module dual_button_integrator_debounce_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: pin_a_level, pin_b_level, now_time[31:0], zero padding
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dbi_pkg::IN_BITS-1:0]   s_tdata,
    // m_tdata: a_pressed, a_rise, a_fall, a_duration[31:0], b_pressed, b_rise,
    // b_fall, b_duration[31:0], reset_request, zero padding
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dbi_pkg::OUT_BITS-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbi_pkg::ADDR_BITS-1:0] paddr,
    input  logic [dbi_pkg::APB_BITS-1:0]  pwdata,
    output logic [dbi_pkg::APB_BITS-1:0]  prdata,
    output logic                          pready
);
    import dbi_pkg::*;

    logic [CNT_BITS-1:0]  max_reg, max_next;
    logic [HOLD_BITS-1:0] hold_reg, hold_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s_accept;
    logic                 merge_ready;
    logic                 cfg_write;
    reg_index_t           cfg_index;
    lane_out_t            lane_a, lane_b;
    logic [TIME_BITS-1:0] now_time;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb begin
        max_next  = max_reg;
        hold_next = hold_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_INTEGRATOR_MAX: max_next  = pwdata[CNT_BITS-1:0];
                REG_RESET_HOLD:     hold_next = pwdata[HOLD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_INTEGRATOR_MAX: prdata = APB_BITS'(max_reg);
            REG_RESET_HOLD:     prdata = APB_BITS'(hold_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg  <= INTEGRATOR_MAX_RESET;
            hold_reg <= RESET_HOLD_TIME_RESET;
        end else begin
            max_reg  <= max_next;
            hold_reg <= hold_next;
        end
    end

    assign s_tready = !s1_valid_reg || merge_ready;
    assign s_accept = s_tvalid && s_tready;
    assign now_time = s_tdata[2 +: TIME_BITS];

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (merge_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    dbi_lane u_lane_a (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (s_accept),
        .pin_level      (s_tdata[0]),
        .now_time       (now_time),
        .integrator_max (max_reg),
        .lane_out       (lane_a)
    );

    dbi_lane u_lane_b (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (s_accept),
        .pin_level      (s_tdata[1]),
        .now_time       (now_time),
        .integrator_max (max_reg),
        .lane_out       (lane_b)
    );

    dbi_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s1_valid_reg),
        .in_ready        (merge_ready),
        .lane_a          (lane_a),
        .lane_b          (lane_b),
        .reset_hold_time (hold_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

FILE: tb/sv/tb_dual_button_integrator_debounce_unit.sv
// Self-checking testbench for the dual button debouncer: drives sample requests over the
// input stream, programs both registers over APB, and checks every result against a
// cycle-free model of the integrators and edge trackers. Depends on dbi_pkg and the unit.
module tb_dual_button_integrator_debounce_unit;
    import dbi_pkg::*;

    localparam int TOTAL_ITEMS = 1853;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT = 100;

    typedef enum int {
        PACE_RECV_SLOW,
        PACE_SEND_SLOW,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        lane_out_t a;
        lane_out_t b;
        logic      reset_request;
    } tick_result_t;

    class debounce_scoreboard;
        logic [CNT_BITS-1:0]  max_count;
        logic [HOLD_BITS-1:0] hold_time;
        logic [CNT_BITS-1:0]  count [2];
        logic                 level [2];
        edge_phase_t          phase [2];
        logic [TIME_BITS-1:0] start [2];
        tick_result_t         expected_q [$];
        int                   errors;

        function new();
            max_count = INTEGRATOR_MAX_RESET;
            hold_time = RESET_HOLD_TIME_RESET;
            for (int b = 0; b < 2; b++) begin
                count[b] = '0;
                level[b] = 1'b0;
                phase[b] = PH_UNPRESSED;
                start[b] = '0;
            end
            errors = 0;
        endfunction

        function void write_register(reg_index_t idx, logic [APB_BITS-1:0] value);
            case (idx)
                REG_INTEGRATOR_MAX: max_count = value[CNT_BITS-1:0];
                REG_RESET_HOLD:     hold_time = value[HOLD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function lane_out_t debounce_lane(int b, logic pin, logic [TIME_BITS-1:0] now);
            lane_out_t r;
            if (phase[b] == PH_RISING) begin
                phase[b] = PH_PRESSED;
            end else if (phase[b] == PH_FALLING) begin
                phase[b] = PH_UNPRESSED;
            end
            if (!pin) begin
                if (count[b] != 0) count[b] = count[b] - 1'b1;
            end else if (count[b] < max_count) begin
                count[b] = count[b] + 1'b1;
            end
            // A zero count wins over the maximum, so a maximum of zero keeps the level low.
            if (count[b] == 0) begin
                if (level[b]) phase[b] = PH_FALLING;
                level[b] = 1'b0;
            end else if (count[b] >= max_count) begin
                if (phase[b] == PH_UNPRESSED) begin
                    start[b] = now;
                    phase[b] = PH_RISING;
                end
                level[b] = 1'b1;
                count[b] = max_count;
            end
            r.pressed  = level[b];
            r.rise     = (phase[b] == PH_RISING);
            r.fall     = (phase[b] == PH_FALLING);
            r.duration = level[b] ? now - start[b] : '0;
            return r;
        endfunction

        function void note_request(logic pin_a, logic pin_b, logic [TIME_BITS-1:0] now);
            tick_result_t t;
            t.a = debounce_lane(0, pin_a, now);
            t.b = debounce_lane(1, pin_b, now);
            t.reset_request = (t.a.duration > hold_time) && (t.b.duration > hold_time);
            expected_q.push_back(t);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [TIME_BITS-1:0] got, logic [TIME_BITS-1:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(logic [OUT_BITS-1:0] d);
            tick_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0h arrived with nothing outstanding", d));
            end else begin
                want = expected_q.pop_front();
                compare_field("a_pressed", d[A_PRESSED_BIT], want.a.pressed);
                compare_field("a_rise", d[A_RISE_BIT], want.a.rise);
                compare_field("a_fall", d[A_FALL_BIT], want.a.fall);
                compare_field("a_duration", d[A_DUR_LSB +: TIME_BITS], want.a.duration);
                compare_field("b_pressed", d[B_PRESSED_BIT], want.b.pressed);
                compare_field("b_rise", d[B_RISE_BIT], want.b.rise);
                compare_field("b_fall", d[B_FALL_BIT], want.b.fall);
                compare_field("b_duration", d[B_DUR_LSB +: TIME_BITS], want.b.duration);
                compare_field("reset_request", d[REQ_BIT], want.reset_request);
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_BITS-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [APB_BITS-1:0]  pwdata = '0;
    logic [APB_BITS-1:0]  prdata;
    logic                 pready;

    debounce_scoreboard   sb;
    pace_t                pace = PACE_RECV_SLOW;
    int                   sent_count = 0;
    int                   stall_cycles = 0;
    logic [TIME_BITS-1:0] tick_now = '0;
    logic                 seg_level [2] = '{1'b0, 1'b0};
    int                   seg_left [2] = '{0, 0};
    int                   bounce_left [2] = '{0, 0};

    dual_button_integrator_debounce_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        case (pace)
            PACE_RECV_SLOW: m_tready <= ($urandom_range(99) >= 82);
            PACE_SEND_SLOW: m_tready <= ($urandom_range(99) >= 27);
            default:        m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_dual_button_integrator_debounce_unit: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_req(logic pin_a, logic pin_b, logic [TIME_BITS-1:0] now);
        int idle_pct;
        pace = (sent_count * 3 < TOTAL_ITEMS) ? PACE_RECV_SLOW :
               (sent_count * 3 < 2 * TOTAL_ITEMS) ? PACE_SEND_SLOW : PACE_FULL;
        idle_pct = (pace == PACE_RECV_SLOW) ? 27 : (pace == PACE_SEND_SLOW) ? 82 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BITS - IN_FIELD_BITS){1'b0}}, now, pin_b, pin_a};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(pin_a, pin_b, now);
        sent_count++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [APB_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [CNT_BITS-1:0] max_count, logic [HOLD_BITS-1:0] hold);
        logic [APB_BITS-1:0] v;
        // Upper bits of the maximum register write are junk and must be dropped.
        v = $urandom();
        v[CNT_BITS-1:0] = max_count;
        write_reg(REG_INTEGRATOR_MAX, v);
        write_reg(REG_RESET_HOLD, hold);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic next_pin(int b);
        int m;
        m = (sb.max_count == 0) ? 4 : int'(sb.max_count);
        if (seg_left[b] == 0) begin
            if ($urandom_range(99) < 70) seg_level[b] = !seg_level[b];
            seg_left[b] = $urandom_range(2 * m + 6, m / 2 + 1);
            bounce_left[b] = $urandom_range(m / 2 + 2, 0);
        end
        seg_left[b]--;
        if (bounce_left[b] > 0) begin
            bounce_left[b]--;
            return logic'($urandom_range(1, 0));
        end
        return seg_level[b];
    endfunction

    task automatic run_phase(int n_items);
        int   r;
        logic pa;
        logic pb;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                tick_now = $urandom();
            end else if (r < 8) begin
                tick_now = tick_now + $urandom_range(50, 2);
            end else begin
                tick_now = tick_now + 1'b1;
            end
            pa = next_pin(0);
            pb = next_pin(1);
            if ($urandom_range(99) < 10) begin
                pa = logic'($urandom_range(1, 0));
                pb = logic'($urandom_range(1, 0));
            end
            send_req(pa, pb, tick_now);
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Press the first button across the time wrap, then both, until a reset request.
        send_req(1'b0, 1'b0, '0);
        for (int i = 0; i < 11; i++) send_req(1'b1, 1'b0, 32'hFFFF_FFF0 + i);
        send_req(1'b1, 1'b1, 32'hFFFF_FFFF);
        for (int i = 0; i < 9; i++) send_req(1'b1, 1'b1, 32'h0000_2000 + i);
        send_req(1'b1, 1'b1, 32'h0000_3000);
        wait_drained();

        run_phase(250);
        wait_drained();
        configure(8'd1, 32'd0);
        run_phase(250);
        wait_drained();
        configure(8'd255, 32'hFFFF_FFFF);
        run_phase(500);
        wait_drained();
        // Counts left near 255 above are clamped by the much lower maximum.
        configure(8'd4, 32'd12);
        run_phase(250);
        wait_drained();
        configure(8'd0, 32'd5);
        run_phase(150);
        wait_drained();
        configure(8'd3, 32'd30);
        run_phase(430);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_dual_button_integrator_debounce_unit: PASS");
        end else begin
            $display("tb_dual_button_integrator_debounce_unit: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dbi_pkg.sv
rtl/core/dbi_lane.sv
rtl/core/dbi_merge.sv
rtl/core/dual_button_integrator_debounce_unit.sv
tb/sv/tb_dual_button_integrator_debounce_unit.sv
